// ===== rtl/pgf_pkg.sv =====
// Package for the process grid factoriser.
// Holds field widths, status codes and the sequencer state type.
// No dependencies.
`default_nettype none
package pgf_pkg;
  localparam int RankW   = 16;
  localparam int VoxW    = 20;
  localparam int DivW    = 16;
  localparam int ScoreW  = 60;
  localparam int StatusW = 2;
  localparam int ProdW   = 2 * VoxW;

  localparam logic [StatusW-1:0] StOk     = 2'd0;
  localparam logic [StatusW-1:0] StZero   = 2'd1;
  localparam logic [StatusW-1:0] StNoGrid = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_I_START, S_I_CHK, S_J_START, S_J_CHK, S_LX, S_LY, S_LZ,
    S_HALO, S_CMP, S_J_NEXT, S_I_NEXT, S_FIN
  } state_e;
endpackage
`default_nettype wire

// ===== rtl/process_grid_factorizer_top.sv =====
// Process grid factoriser top level: sequencer around one shared restoring
// divider and one shared multiplier. Depends on pgf_pkg.
// A zero extent or a count of 0 or 1 answers in the cycle after accept; otherwise the
// sequencer divides for each candidate i and j, then scores each triple that fits. One
// item at a time: busy stays high until the one-cycle result beat on done_o (no stall).
// Async reset returns to idle.
`default_nettype none
module process_grid_factorizer_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pgf_pkg::RankW-1:0]     rank_count_i,
  input  wire logic [pgf_pkg::VoxW-1:0]      vox_x_i,
  input  wire logic [pgf_pkg::VoxW-1:0]      vox_y_i,
  input  wire logic [pgf_pkg::VoxW-1:0]      vox_z_i,
  input  wire logic                          policy_i,
  output logic                               done_o,
  output logic [pgf_pkg::DivW-1:0]           div_x_o,
  output logic [pgf_pkg::DivW-1:0]           div_y_o,
  output logic [pgf_pkg::DivW-1:0]           div_z_o,
  output logic [pgf_pkg::ScoreW-1:0]         best_score_o,
  output logic [pgf_pkg::StatusW-1:0]        status_o
);
  localparam int RW = pgf_pkg::RankW;
  localparam int VW = pgf_pkg::VoxW;
  localparam int SW = pgf_pkg::ScoreW;
  localparam int PW = pgf_pkg::ProdW;

  pgf_pkg::state_e state_q, state_d, ret_q, ret_d;

  logic [RW-1:0] n_q, n_d;
  logic [VW-1:0] vx_q, vx_d, vy_q, vy_d, vz_q, vz_d;
  logic          pol_q, pol_d;
  logic [RW:0]   i_q, i_d, j_q, j_d;
  logic [RW-1:0] rest_q, rest_d, k_q, k_d;
  logic [VW-1:0] lx_q, lx_d, ly_q, ly_d, lz_q, lz_d;
  logic [RW-1:0] bi_q, bi_d, bj_q, bj_d, bk_q, bk_d;
  logic [SW-1:0] best_q, best_d, sc_q, sc_d;
  logic          found_q, found_d;
  logic [PW-1:0] p_q, p_d;
  logic [2:0]    h_q, h_d;

  // shared divider
  logic [VW-1:0] dvd_q, dvd_d, quo_q, quo_d;
  logic [RW-1:0] dvs_q, dvs_d, rem_q, rem_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [RW:0]   trial;
  logic          fits;

  // shared multiplier
  logic [PW-1:0] mul_a;
  logic [VW-1:0] mul_b;
  logic [SW-1:0] mul_p;

  logic [VW-1:0] mx, mn;

  logic          done_d;
  logic [RW-1:0] odx_d, ody_d, odz_d;
  logic [SW-1:0] osc_d;
  logic [1:0]    ost_d;

  assign trial = {rem_q, dvd_q[VW-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign mul_p = {{(SW-PW){1'b0}}, mul_a} * {{(SW-VW){1'b0}}, mul_b};

  always_comb begin
    mul_a = p_q;
    mul_b = '0;
    case (h_q)
      3'd0: begin mul_a = {{(PW-VW){1'b0}}, ly_q}; mul_b = lz_q; end
      3'd1: begin mul_a = p_q; mul_b = {{(VW-RW){1'b0}}, i_q[RW-1:0] - 1'b1}; end
      3'd2: begin mul_a = {{(PW-VW){1'b0}}, lz_q}; mul_b = lx_q; end
      3'd3: begin mul_a = p_q; mul_b = {{(VW-RW){1'b0}}, j_q[RW-1:0] - 1'b1}; end
      3'd4: begin mul_a = {{(PW-VW){1'b0}}, lx_q}; mul_b = ly_q; end
      3'd5: begin mul_a = p_q; mul_b = {{(VW-RW){1'b0}}, k_q - 1'b1}; end
      default: begin mul_a = p_q; mul_b = '0; end
    endcase
  end

  always_comb begin
    mx = lx_q;
    mn = lx_q;
    if (ly_q > mx) mx = ly_q;
    if (lz_q > mx) mx = lz_q;
    if (ly_q < mn) mn = ly_q;
    if (lz_q < mn) mn = lz_q;
  end

  always_comb begin
    state_d = state_q; ret_d = ret_q;
    n_d = n_q; vx_d = vx_q; vy_d = vy_q; vz_d = vz_q; pol_d = pol_q;
    i_d = i_q; j_d = j_q; rest_d = rest_q; k_d = k_q;
    lx_d = lx_q; ly_d = ly_q; lz_d = lz_q;
    bi_d = bi_q; bj_d = bj_q; bk_d = bk_q; best_d = best_q; found_d = found_q;
    sc_d = sc_q; p_d = p_q; h_d = h_q;
    dvd_d = dvd_q; dvs_d = dvs_q; rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q;
    done_d = 1'b0;
    odx_d = div_x_o; ody_d = div_y_o; odz_d = div_z_o;
    osc_d = best_score_o; ost_d = status_o;
    case (state_q)
      pgf_pkg::S_IDLE: begin
        if (start) begin
          n_d = rank_count_i; vx_d = vox_x_i; vy_d = vox_y_i; vz_d = vox_z_i;
          pol_d = policy_i; found_d = 1'b0; best_d = '0;
          if (vox_x_i == '0 || vox_y_i == '0 || vox_z_i == '0) begin
            done_d = 1'b1; odx_d = '0; ody_d = '0; odz_d = '0; osc_d = '0;
            ost_d = pgf_pkg::StZero;
          end else if (rank_count_i <= RW'(1)) begin
            done_d = 1'b1; odx_d = RW'(1); ody_d = RW'(1); odz_d = RW'(1);
            osc_d = '0; ost_d = pgf_pkg::StOk;
          end else begin
            i_d = (RW+1)'(1);
            state_d = pgf_pkg::S_I_START;
          end
        end
      end
      pgf_pkg::S_DIV: begin
        dvd_d = {dvd_q[VW-2:0], 1'b0};
        rem_d = fits ? RW'(trial - {1'b0, dvs_q}) : trial[RW-1:0];
        quo_d = {quo_q[VW-2:0], fits};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'(VW-1)) state_d = ret_q;
      end
      pgf_pkg::S_I_START: begin
        dvd_d = {{(VW-RW){1'b0}}, n_q}; dvs_d = i_q[RW-1:0];
        rem_d = '0; quo_d = '0; cnt_d = '0;
        ret_d = pgf_pkg::S_I_CHK; state_d = pgf_pkg::S_DIV;
      end
      pgf_pkg::S_I_CHK: begin
        if (rem_q != '0) state_d = pgf_pkg::S_I_NEXT;
        else if ({{(VW-RW-1){1'b0}}, i_q} > vx_q) state_d = pgf_pkg::S_FIN;
        else begin
          rest_d = quo_q[RW-1:0]; j_d = (RW+1)'(1);
          state_d = pgf_pkg::S_J_START;
        end
      end
      pgf_pkg::S_J_START: begin
        dvd_d = {{(VW-RW){1'b0}}, rest_q}; dvs_d = j_q[RW-1:0];
        rem_d = '0; quo_d = '0; cnt_d = '0;
        ret_d = pgf_pkg::S_J_CHK; state_d = pgf_pkg::S_DIV;
      end
      pgf_pkg::S_J_CHK: begin
        if (rem_q != '0) state_d = pgf_pkg::S_J_NEXT;
        else if ({{(VW-RW-1){1'b0}}, j_q} > vy_q) state_d = pgf_pkg::S_I_NEXT;
        else if (quo_q > vz_q) state_d = pgf_pkg::S_J_NEXT;
        else begin
          k_d = quo_q[RW-1:0];
          dvd_d = vx_q; dvs_d = i_q[RW-1:0];
          rem_d = '0; quo_d = '0; cnt_d = '0;
          ret_d = pgf_pkg::S_LX; state_d = pgf_pkg::S_DIV;
        end
      end
      pgf_pkg::S_LX: begin
        lx_d = quo_q;
        dvd_d = vy_q; dvs_d = j_q[RW-1:0];
        rem_d = '0; quo_d = '0; cnt_d = '0;
        ret_d = pgf_pkg::S_LY; state_d = pgf_pkg::S_DIV;
      end
      pgf_pkg::S_LY: begin
        ly_d = quo_q;
        dvd_d = vz_q; dvs_d = k_q;
        rem_d = '0; quo_d = '0; cnt_d = '0;
        ret_d = pgf_pkg::S_LZ; state_d = pgf_pkg::S_DIV;
      end
      pgf_pkg::S_LZ: begin
        lz_d = quo_q;
        h_d = '0; sc_d = '0;
        state_d = pgf_pkg::S_HALO;
      end
      pgf_pkg::S_HALO: begin
        // score bounded below 2^59 for these widths: no saturation reached
        if (pol_q) begin
          sc_d = {{(SW-VW){1'b0}}, mx - mn};
          state_d = pgf_pkg::S_CMP;
        end else begin
          if (h_q[0]) sc_d = sc_q + mul_p;
          else p_d = mul_p[PW-1:0];
          h_d = h_q + 1'b1;
          if (h_q == 3'd5) state_d = pgf_pkg::S_CMP;
        end
      end
      pgf_pkg::S_CMP: begin
        if (!found_q || sc_q < best_q) begin
          found_d = 1'b1; best_d = sc_q;
          bi_d = i_q[RW-1:0]; bj_d = j_q[RW-1:0]; bk_d = k_q;
        end
        state_d = pgf_pkg::S_J_NEXT;
      end
      pgf_pkg::S_J_NEXT: begin
        j_d = j_q + 1'b1;
        if (j_q >= {1'b0, rest_q}) state_d = pgf_pkg::S_I_NEXT;
        else state_d = pgf_pkg::S_J_START;
      end
      pgf_pkg::S_I_NEXT: begin
        i_d = i_q + 1'b1;
        if (i_q >= {1'b0, n_q}) state_d = pgf_pkg::S_FIN;
        else state_d = pgf_pkg::S_I_START;
      end
      pgf_pkg::S_FIN: begin
        done_d = 1'b1;
        if (found_q) begin
          odx_d = bi_q; ody_d = bj_q; odz_d = bk_q; osc_d = best_q;
          ost_d = pgf_pkg::StOk;
        end else begin
          odx_d = '0; ody_d = '0; odz_d = '0; osc_d = '0;
          ost_d = pgf_pkg::StNoGrid;
        end
        state_d = pgf_pkg::S_IDLE;
      end
      default: state_d = pgf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pgf_pkg::S_IDLE;
      ret_q   <= pgf_pkg::S_IDLE;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      done_o  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; vx_q <= vx_d; vy_q <= vy_d; vz_q <= vz_d; pol_q <= pol_d;
    i_q <= i_d; j_q <= j_d; rest_q <= rest_d; k_q <= k_d;
    lx_q <= lx_d; ly_q <= ly_d; lz_q <= lz_d;
    bi_q <= bi_d; bj_q <= bj_d; bk_q <= bk_d; best_q <= best_d;
    found_q <= found_d; sc_q <= sc_d; p_q <= p_d; h_q <= h_d;
    dvd_q <= dvd_d; dvs_q <= dvs_d; rem_q <= rem_d; quo_q <= quo_d; cnt_q <= cnt_d;
    div_x_o <= odx_d; div_y_o <= ody_d; div_z_o <= odz_d;
    best_score_o <= osc_d; status_o <= ost_d;
  end

  assign busy = (state_q != pgf_pkg::S_IDLE);
endmodule
`default_nettype wire

// ===== sim/tb_process_grid_factorizer_top.sv =====
// Self-checking testbench for process_grid_factorizer_top: directed and random
// beats, a scoreboard class with its own grid search, and random idle bursts.
// Depends on pgf_pkg and the top-level RTL.
`default_nettype none
module tb_process_grid_factorizer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pgf_pkg::*;

  typedef struct {
    logic [RankW-1:0] ranks;
    logic [VoxW-1:0]  vx, vy, vz;
    logic             pol;
  } grid_req_t;

  typedef struct {
    logic [DivW-1:0]    dx, dy, dz;
    logic [ScoreW-1:0]  score;
    logic [StatusW-1:0] st;
  } grid_res_t;

  class grid_scoreboard;
    grid_res_t pending[$];
    int        errors = 0;

    function logic [127:0] cap(logic [127:0] v);
      logic [127:0] lim;
      lim = (128'd1 << ScoreW) - 1;
      return (v > lim) ? lim : v;
    endfunction

    function grid_res_t best_grid(grid_req_t r);
      grid_res_t    res;
      logic [63:0]  n, i, j, k, rest, lx, ly, lz, mn, mx;
      logic [127:0] sc, best;
      bit           found;
      res = '{default: '0};
      n = r.ranks;
      best = 0;
      found = 0;
      if (r.vx == 0 || r.vy == 0 || r.vz == 0) begin
        res.st = StZero;
        return res;
      end
      if (n <= 1) begin
        res.dx = 1; res.dy = 1; res.dz = 1; res.st = StOk;
        return res;
      end
      for (i = 1; i <= n; i++) begin
        if (n % i != 0) continue;
        if (i > r.vx) break;
        rest = n / i;
        for (j = 1; j <= rest; j++) begin
          if (rest % j != 0) continue;
          if (j > r.vy) break;
          k = rest / j;
          if (k > r.vz) continue;
          lx = r.vx / i; ly = r.vy / j; lz = r.vz / k;
          if (r.pol) begin
            mn = lx; mx = lx;
            if (ly < mn) mn = ly;
            if (lz < mn) mn = lz;
            if (ly > mx) mx = ly;
            if (lz > mx) mx = lz;
            sc = mx - mn;
          end else begin
            sc = cap(cap(ly * lz) * (i - 1));
            sc = cap(sc + cap(cap(lz * lx) * (j - 1)));
            sc = cap(sc + cap(cap(lx * ly) * (k - 1)));
          end
          if (!found || sc < best) begin
            res.dx = i[DivW-1:0]; res.dy = j[DivW-1:0]; res.dz = k[DivW-1:0];
            best = sc;
            found = 1;
          end
        end
      end
      if (!found) begin
        res = '{default: '0};
        res.st = StNoGrid;
        return res;
      end
      res.score = best[ScoreW-1:0];
      res.st = StOk;
      return res;
    endfunction

    function void note_request(grid_req_t r);
      pending.push_back(best_grid(r));
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(grid_res_t got);
      grid_res_t want;
      if (pending.size() == 0) begin
        report("unexpected beat", 1, 0);
        return;
      end
      want = pending.pop_front();
      if (got.dx !== want.dx) report("div_x", got.dx, want.dx);
      if (got.dy !== want.dy) report("div_y", got.dy, want.dy);
      if (got.dz !== want.dz) report("div_z", got.dz, want.dz);
      if (got.score !== want.score) report("best_score", got.score, want.score);
      if (got.st !== want.st) report("status", got.st, want.st);
    endtask
  endclass

  logic             clk_i = 0;
  logic             rst_ni = 0;
  logic             start = 0;
  logic [RankW-1:0] rank_count_i = '0;
  logic [VoxW-1:0]  vox_x_i = '0, vox_y_i = '0, vox_z_i = '0;
  logic             policy_i = 0;
  logic             busy, done_o;
  logic [DivW-1:0]  div_x_o, div_y_o, div_z_o;
  logic [ScoreW-1:0] best_score_o;
  logic [StatusW-1:0] status_o;

  grid_scoreboard sb = new();

  process_grid_factorizer_top u_top (
    .clk_i, .rst_ni, .start, .busy, .rank_count_i, .vox_x_i, .vox_y_i, .vox_z_i,
    .policy_i, .done_o, .div_x_o, .div_y_o, .div_z_o, .best_score_o, .status_o
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    grid_res_t r;
    if (rst_ni && done_o) begin
      r.dx = div_x_o; r.dy = div_y_o; r.dz = div_z_o;
      r.score = best_score_o; r.st = status_o;
      sb.check_result(r);
    end
  end

  task send_beat(logic [RankW-1:0] n, logic [VoxW-1:0] x, logic [VoxW-1:0] y,
                 logic [VoxW-1:0] z, logic p);
    grid_req_t r;
    @(negedge clk_i);
    start <= 1; rank_count_i <= n; vox_x_i <= x; vox_y_i <= y; vox_z_i <= z;
    policy_i <= p;
    do @(posedge clk_i); while (busy);
    r.ranks = n; r.vx = x; r.vy = y; r.vz = z; r.pol = p;
    sb.note_request(r);
  endtask

  task idle_burst(int n);
    @(negedge clk_i);
    start <= 0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task random_beat(bit gaps);
    logic [RankW-1:0] n;
    logic [VoxW-1:0]  x, y, z;
    int               sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      // large count, multiple of 256, with narrow first and second axes so both scans
      // stop early
      n = {8'($urandom_range(1, 255)), 8'h00};
      x = VoxW'($urandom_range(1, 3));
      y = VoxW'($urandom_range(1, 3));
    end else begin
      n = RankW'($urandom_range(0, 300));
      x = (sel < 4) ? VoxW'($urandom_range(1, 1048575)) : VoxW'($urandom_range(1, 40));
      y = (sel < 4) ? VoxW'($urandom_range(0, 1048575)) : VoxW'($urandom_range(1, 40));
    end
    z = (sel < 4) ? VoxW'($urandom_range(0, 1048575)) : VoxW'($urandom_range(1, 40));
    if ($urandom_range(0, 15) == 0) y = 0;
    send_beat(n, x, y, z, 1'($urandom_range(0, 1)));
    if (gaps && $urandom_range(0, 2) == 0) idle_burst(int'($urandom_range(1, 6)));
  endtask

  initial begin
    #100ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    send_beat(16'd12, 20'd0, 20'd5, 20'd5, 0);
    send_beat(16'd12, 20'd5, 20'd0, 20'd5, 1);
    send_beat(16'd12, 20'd5, 20'd5, 20'd0, 0);
    send_beat(16'd0, 20'd7, 20'd7, 20'd7, 0);
    send_beat(16'd1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1);
    send_beat(16'd7, 20'd1, 20'd1, 20'd1, 0);
    send_beat(16'd7, 20'd1, 20'd1, 20'd1, 1);
    send_beat(16'hFFFF, 20'd1, 20'd1, 20'hFFFFF, 0);
    send_beat(16'hFFFF, 20'd2, 20'd1, 20'hFFFFF, 1);
    send_beat(16'd64, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 0);
    send_beat(16'd64, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1);
    send_beat(16'd12, 20'd2, 20'd3, 20'd2, 0);
    send_beat(16'd8, 20'd8, 20'd8, 20'd8, 0);
    send_beat(16'd8, 20'd8, 20'd8, 20'd8, 1);
    send_beat(16'd30, 20'd100, 20'd3, 20'd1, 0);
    idle_burst(1);
    wait (sb.pending.size() == 0);
    repeat (60) begin
      random_beat(1);
    end
    idle_burst(1);
    wait (sb.pending.size() == 0);
    idle_burst(int'($urandom_range(1, 6)));
    repeat (25) random_beat(0);
    idle_burst(1);
    wait (sb.pending.size() == 0);
    repeat (50) @(posedge clk_i);
    if (sb.pending.size() != 0) sb.report("results outstanding", sb.pending.size(), 0);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== process_grid_factorizer_top.f =====
rtl/pgf_pkg.sv
rtl/process_grid_factorizer_top.sv
sim/tb_process_grid_factorizer_top.sv
